// ----- hdl/slm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package slm_pkg;

    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int WINDOW_DEPTH_DEF   = 1024;
    localparam int PERIOD_WINDOWS_DEF = 1024;

    localparam int DB_W    = 16;
    localparam int FLOOR_W = 23;
    localparam int MAXS_W  = 11;
    localparam int CFG_W   = 23;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_DB_OFFSET = 2'd0;
    localparam logic [IDX_W-1:0] REG_VAR_FLOOR = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_SAMP  = 2'd2;

    // 3.0103 in Q14
    localparam logic [15:0] LOG_SCALE_Q14 = 16'd49321;
    localparam int VAR_W  = 31;
    localparam int EXP_W  = 5;
    localparam int FRAC_W = 8;

    localparam logic signed [DB_W-1:0] DB_MAX = 16'sh7FFF;
    localparam logic signed [DB_W-1:0] DB_MIN = -16'sh8000;

endpackage
`default_nettype wire

// ----- hdl/slm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module slm_div #(
    parameter int N = 45,
    parameter int D = 22
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              done,
    output logic [N-1:0]      quotient
);
    localparam int CNT_W = $clog2(N + 1);

    logic [D-1:0]     rem_reg;
    logic [N-1:0]     quo_reg;
    logic [D-1:0]     den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D:0]       shifted;
    logic             fits;

    assign shifted  = {rem_reg, quo_reg[N-1]};
    assign fits     = shifted >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= D'(shifted - {1'b0, den_reg});
            else
                rem_reg <= shifted[D-1:0];
            quo_reg <= {quo_reg[N-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sound_level_meter_db_unit.sv -----
// A sample that does not close a window is accumulated and gives no result.
// A closing sample raises out_valid after the close sequence: setup (S_MUL, S_SUB), the
// variance divider, normalization, eight squarings, then the level, sum and output steps;
// a period close also runs the average divider before the output step.
// Throughput: one sample per cycle inside a window; not ready while a close runs.
// Reset (rst_n, async low) clears sums, counts and the average, restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module sound_level_meter_db_unit #(
    parameter int SAMPLE_BITS    = slm_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_DEPTH   = slm_pkg::WINDOW_DEPTH_DEF,
    parameter int PERIOD_WINDOWS = slm_pkg::PERIOD_WINDOWS_DEF,
    localparam int CW            = $clog2(WINDOW_DEPTH + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [SAMPLE_BITS-1:0]          sample,
    input  wire logic                            window_end,
    input  wire logic                            period_end,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [slm_pkg::DB_W-1:0]      window_db,
    output logic signed [slm_pkg::DB_W-1:0]      average_db,
    output logic                                 average_updated,
    output logic [CW-1:0]                        samples_used,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [slm_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [slm_pkg::CFG_W-1:0]       cfg_data
);
    localparam int SUM_W = SAMPLE_BITS + CW;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CW;
    localparam int NUM_W = SQ_W + CW;
    localparam int DEN_W = 2 * CW;
    localparam int WCW   = $clog2(PERIOD_WINDOWS + 1);
    localparam int LS_W  = slm_pkg::DB_W + WCW;
    localparam int DIV_N = (NUM_W > LS_W) ? NUM_W : LS_W;
    localparam int DIV_D = (DEN_W > WCW) ? DEN_W : WCW;
    localparam int LVL_W = slm_pkg::EXP_W + slm_pkg::FRAC_W;
    localparam int VW    = slm_pkg::VAR_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SUB   = 4'd2;
    localparam logic [3:0] S_VDIV  = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_SQ2   = 4'd6;
    localparam logic [3:0] S_LVL   = 4'd7;
    localparam logic [3:0] S_ADD   = 4'd8;
    localparam logic [3:0] S_PEND  = 4'd9;
    localparam logic [3:0] S_ADIV  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg, state_next;

    logic signed [slm_pkg::DB_W-1:0] db_offset_reg;
    logic [slm_pkg::FLOOR_W-1:0]     floor_reg;
    logic [slm_pkg::MAXS_W-1:0]      max_samples_reg;

    logic [SUM_W-1:0]        sum_reg;
    logic [SQ_W-1:0]         sqsum_reg;
    logic [CW-1:0]           count_reg;
    logic signed [LS_W-1:0]  lsum_reg;
    logic [WCW-1:0]          wcount_reg;
    logic signed [slm_pkg::DB_W-1:0] avg_reg;

    logic [NUM_W-1:0]        nsq_reg, ssq_reg;
    logic [DIV_D-1:0]        den_reg;
    logic [CW-1:0]           used_reg;
    logic                    pend_reg;
    logic                    neg_reg;
    logic                    upd_reg;
    logic [VW-1:0]           y_reg;
    logic [2*VW-1:0]         prod_reg;
    logic [slm_pkg::EXP_W-1:0]  e_reg;
    logic [slm_pkg::FRAC_W-1:0] frac_reg;
    logic [3:0]              it_reg;
    logic [LVL_W-1:0]        level_reg;
    logic signed [slm_pkg::DB_W-1:0] wdb_reg;

    logic                    div_start, div_done;
    logic [DIV_N-1:0]        div_q;
    logic [DIV_N-1:0]        div_num;
    logic [DIV_D-1:0]        div_den;

    logic [31:0]             ms_ext;
    logic [CW-1:0]           limit;
    logic                    in_fire;
    logic [CW-1:0]           count_inc;
    logic                    closing;
    logic [DIV_N+VW-1:0]     q_ext;
    logic [VW-1:0]           q_var;
    logic [VW-1:0]           floor_v;
    logic [31:0]             sq_top;
    logic [LVL_W+16:0]       lvl_prod;
    logic signed [slm_pkg::DB_W+2:0] wdb_wide;
    logic signed [slm_pkg::DB_W-1:0] wdb_sat;
    logic [LS_W-1:0]         lsum_mag;
    logic signed [DIV_N:0]   avg_wide;
    logic signed [slm_pkg::DB_W-1:0] avg_sat;

    slm_div #(.N(DIV_N), .D(DIV_D)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        ms_ext = 32'(max_samples_reg);
        if (max_samples_reg == '0)
            limit = CW'(1);
        else if (ms_ext > 32'(WINDOW_DEPTH))
            limit = CW'(WINDOW_DEPTH);
        else
            limit = ms_ext[CW-1:0];
    end

    assign count_inc = count_reg + 1'b1;
    assign closing   = window_end || (count_inc >= limit);

    assign q_ext   = {{VW{1'b0}}, div_q};
    assign q_var   = (div_q > {{(DIV_N-VW){1'b0}}, {VW{1'b1}}}) ? {VW{1'b1}} : q_ext[VW-1:0];
    assign floor_v = (floor_reg == '0) ? VW'(1) : VW'(floor_reg);
    assign sq_top  = prod_reg[2*VW-1:VW-1];

    assign lvl_prod = (LVL_W + 17)'({e_reg, frac_reg}) * (LVL_W + 17)'(slm_pkg::LOG_SCALE_Q14)
                      + (LVL_W + 17)'(32768);
    assign wdb_wide = $signed({6'b0, level_reg}) + (slm_pkg::DB_W + 3)'(db_offset_reg);

    always_comb
    begin
        if (wdb_wide > (slm_pkg::DB_W + 3)'(slm_pkg::DB_MAX))
            wdb_sat = slm_pkg::DB_MAX;
        else if (wdb_wide < (slm_pkg::DB_W + 3)'(slm_pkg::DB_MIN))
            wdb_sat = slm_pkg::DB_MIN;
        else
            wdb_sat = wdb_wide[slm_pkg::DB_W-1:0];
    end

    assign lsum_mag = lsum_reg[LS_W-1] ? LS_W'(-lsum_reg) : LS_W'(lsum_reg);
    assign avg_wide = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    always_comb
    begin
        if (avg_wide > (DIV_N + 1)'(slm_pkg::DB_MAX))
            avg_sat = slm_pkg::DB_MAX;
        else if (avg_wide < (DIV_N + 1)'(slm_pkg::DB_MIN))
            avg_sat = slm_pkg::DB_MIN;
        else
            avg_sat = avg_wide[slm_pkg::DB_W-1:0];
    end

    // the divider loads its operands on the start cycle
    assign div_num   = (state_reg == S_SUB) ? DIV_N'(nsq_reg - ssq_reg) : DIV_N'(lsum_mag);
    assign div_den   = (state_reg == S_SUB) ? den_reg : DIV_D'(wcount_reg);
    assign div_start = (state_reg == S_SUB) ||
                       (state_reg == S_PEND && pend_reg && wcount_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire && closing) state_next = S_MUL;
            S_MUL:  state_next = S_SUB;
            S_SUB:  state_next = S_VDIV;
            S_VDIV: if (div_done) state_next = S_NORM;
            S_NORM: if (y_reg[VW-1]) state_next = S_SQ;
            S_SQ:   state_next = S_SQ2;
            S_SQ2:  state_next = (it_reg == 4'd7) ? S_LVL : S_SQ;
            S_LVL:  state_next = S_ADD;
            S_ADD:  state_next = S_PEND;
            S_PEND: state_next = (pend_reg && wcount_reg != '0) ? S_ADIV : S_FIN;
            S_ADIV: if (div_done) state_next = S_FIN;
            S_FIN:  if (!out_valid || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            db_offset_reg   <= '0;
            floor_reg       <= slm_pkg::FLOOR_W'(1);
            max_samples_reg <= slm_pkg::MAXS_W'(1024);
            sum_reg         <= '0;
            sqsum_reg       <= '0;
            count_reg       <= '0;
            lsum_reg        <= '0;
            wcount_reg      <= '0;
            avg_reg         <= '0;
            out_valid       <= 1'b0;
            upd_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    slm_pkg::REG_DB_OFFSET: db_offset_reg   <= cfg_data[slm_pkg::DB_W-1:0];
                    slm_pkg::REG_VAR_FLOOR: floor_reg       <= cfg_data;
                    slm_pkg::REG_MAX_SAMP:  max_samples_reg <= cfg_data[slm_pkg::MAXS_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_FIN && (!out_valid || out_ready))
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (in_fire)
            begin
                sum_reg   <= sum_reg + SUM_W'(sample);
                sqsum_reg <= sqsum_reg + SQ_W'(sample) * SQ_W'(sample);
                count_reg <= count_inc;
            end
            // window sums are captured into products; drop them now
            if (state_reg == S_MUL)
            begin
                sum_reg   <= '0;
                sqsum_reg <= '0;
                count_reg <= '0;
                upd_reg   <= 1'b0;
            end
            if (state_reg == S_ADD && wcount_reg != WCW'(PERIOD_WINDOWS))
            begin
                lsum_reg   <= lsum_reg + LS_W'(wdb_sat);
                wcount_reg <= wcount_reg + 1'b1;
            end
            if (state_reg == S_PEND && pend_reg)
            begin
                upd_reg <= 1'b1;
                if (wcount_reg == '0)
                begin
                    lsum_reg <= '0;
                end
            end
            if (state_reg == S_ADIV && div_done)
            begin
                avg_reg    <= avg_sat;
                lsum_reg   <= '0;
                wcount_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            pend_reg <= period_end;
        unique case (state_reg)
            S_MUL:
            begin
                nsq_reg  <= NUM_W'(count_reg) * NUM_W'(sqsum_reg);
                ssq_reg  <= NUM_W'(sum_reg) * NUM_W'(sum_reg);
                den_reg  <= DIV_D'(count_reg) * DIV_D'(count_reg);
                used_reg <= count_reg;
            end
            S_VDIV:
            begin
                y_reg <= (q_var < floor_v) ? floor_v : q_var;
                e_reg <= slm_pkg::EXP_W'(VW - 1);
            end
            S_NORM:
            begin
                // shift until the leading one reaches the top
                if (!y_reg[VW-1])
                begin
                    y_reg <= {y_reg[VW-2:0], 1'b0};
                    e_reg <= e_reg - 1'b1;
                end
                it_reg   <= '0;
                frac_reg <= '0;
            end
            S_SQ:
            begin
                prod_reg <= y_reg * y_reg;
            end
            S_SQ2:
            begin
                frac_reg <= {frac_reg[slm_pkg::FRAC_W-2:0], sq_top[31]};
                y_reg    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                it_reg   <= it_reg + 1'b1;
            end
            S_LVL:
            begin
                level_reg <= lvl_prod[LVL_W+15:16];
            end
            S_ADD:
            begin
                wdb_reg <= wdb_sat;
            end
            S_PEND:
            begin
                neg_reg <= lsum_reg[LS_W-1];
            end
            default: ;
        endcase
        if (state_reg == S_FIN && (!out_valid || out_ready))
        begin
            window_db       <= wdb_reg;
            average_db      <= avg_reg;
            average_updated <= upd_reg;
            samples_used    <= used_reg;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/slm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module slm_checker #(
    parameter int CW = 11
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        window_end,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [slm_pkg::DB_W-1:0]    window_db,
    input wire logic [CW-1:0]               samples_used
);
    // a held result keeps its level
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window_db))
        else $error("result changed while stalled");

    a_used_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_used != '0)
        else $error("empty window reported");

    // a request that closes a window starts the close sequence
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && window_end |=> !in_ready)
        else $error("ready during window close");

endmodule

bind sound_level_meter_db_unit slm_checker #(.CW(CW)) u_slm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .window_end   (window_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window_db    (window_db),
    .samples_used (samples_used)
);
`default_nettype wire

// ----- sim/tb_sound_level_meter_db_unit.sv -----
`timescale 1ns / 1ps
module tb_sound_level_meter_db_unit;

    localparam int SB         = slm_pkg::SAMPLE_BITS_DEF;
    localparam int WD         = slm_pkg::WINDOW_DEPTH_DEF;
    localparam int PW         = slm_pkg::PERIOD_WINDOWS_DEF;
    localparam int DBW        = slm_pkg::DB_W;
    localparam int FLW        = slm_pkg::FLOOR_W;
    localparam int MSW        = slm_pkg::MAXS_W;
    localparam int IW         = slm_pkg::IDX_W;
    localparam int CFW        = slm_pkg::CFG_W;
    localparam int CW         = $clog2(WD + 1);
    localparam int CLOSE_WAIT = 300;
    localparam int WD_LIMIT   = 6000;
    localparam logic [IW-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [DBW-1:0] window_db;
        logic signed [DBW-1:0] average_db;
        logic                  average_updated;
        logic [CW-1:0]         samples_used;
    } level_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [SB-1:0] sample = '0;
    logic window_end = 1'b0;
    logic period_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DBW-1:0] window_db;
    logic signed [DBW-1:0] average_db;
    logic average_updated;
    logic [CW-1:0] samples_used;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IW-1:0] cfg_index = '0;
    logic [CFW-1:0] cfg_data = '0;

    sound_level_meter_db_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample(sample), .window_end(window_end), .period_end(period_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .window_db(window_db), .average_db(average_db),
        .average_updated(average_updated), .samples_used(samples_used),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // predictor state
    logic signed [DBW-1:0] m_offset = '0;
    logic [FLW-1:0]        m_floor = 23'd1;
    logic [MSW-1:0]        m_max = 11'd1024;
    longint unsigned       m_sum = 0;
    longint unsigned       m_sq = 0;
    int unsigned           m_n = 0;
    longint                m_level_sum = 0;
    int unsigned           m_windows = 0;
    logic signed [DBW-1:0] m_average = '0;

    level_t level_q[$];
    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int windows_seen = 0;
    int periods_seen = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int unsigned log2_q8(input longint unsigned x);
        int unsigned e;
        int unsigned frac;
        longint unsigned y;
        e = 0;
        frac = 0;
        if (x == 0) x = 1;
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        y = x << (30 - e);
        for (int i = 0; i < 8; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31))
            begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        return e * 256 + frac;
    endfunction

    task automatic predict_level(input logic [SB-1:0] s, input bit we, pe);
        int unsigned lim;
        longint unsigned n, num, v, fl, lvl;
        longint wdb;
        level_t r;
        lim = m_max;
        if (lim == 0) lim = 1;
        if (lim > WD) lim = WD;
        m_sum += s;
        m_sq += longint'(s) * s;
        m_n++;
        if (!we && m_n < lim) return;
        n = m_n;
        num = n * m_sq - m_sum * m_sum;
        v = num / (n * n);
        fl = (m_floor == 0) ? 1 : m_floor;
        if (v < fl) v = fl;
        lvl = (longint'(log2_q8(v)) * slm_pkg::LOG_SCALE_Q14 + 32768) >> 16;
        wdb = sat16(longint'(lvl) + m_offset);
        // saturate the period accumulator at the window limit
        if (m_windows < PW)
        begin
            m_level_sum += wdb;
            m_windows++;
        end
        r.average_updated = pe;
        if (pe)
        begin
            if (m_windows != 0) m_average = DBW'(sat16(m_level_sum / longint'(m_windows)));
            m_level_sum = 0;
            m_windows = 0;
        end
        r.window_db = DBW'(wdb);
        r.average_db = m_average;
        r.samples_used = CW'(m_n);
        level_q.push_back(r);
        m_sum = 0;
        m_sq = 0;
        m_n = 0;
    endtask

    task automatic send_sample(input logic [SB-1:0] s, input bit we, pe);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        sample <= s;
        window_end <= we;
        period_end <= pe;
        do @(posedge clk); while (!in_ready);
        predict_level(s, we, pe);
        items_sent++;
    endtask

    // hold off the sender until the block has drained every request
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (level_q.size() != 0) @(posedge clk);
        repeat (CLOSE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CFW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            slm_pkg::REG_DB_OFFSET: m_offset = data[DBW-1:0];
            slm_pkg::REG_VAR_FLOOR: m_floor = data[FLW-1:0];
            slm_pkg::REG_MAX_SAMP:  m_max = data[MSW-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFW-1:0] off, flr, mx);
        wait_drained();
        write_reg(slm_pkg::REG_DB_OFFSET, off);
        write_reg(slm_pkg::REG_VAR_FLOOR, flr);
        write_reg(slm_pkg::REG_MAX_SAMP, mx);
    endtask

    task automatic check_field(input string name, input longint exp_v, act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        level_t e;
        if (out_valid && out_ready)
        begin
            if (level_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result window_db %0d", window_db);
            end
            else
            begin
                e = level_q.pop_front();
                check_field("window_db", e.window_db, window_db);
                check_field("average_db", e.average_db, average_db);
                check_field("average_updated", e.average_updated, average_updated);
                check_field("samples_used", e.samples_used, samples_used);
                windows_seen++;
                if (e.average_updated) periods_seen++;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("timeout: no progress for %0d cycles", WD_LIMIT);
            $display("tb_sound_level_meter_db_unit NOT OK");
            $finish;
        end
    end

    task automatic test_field_extremes();
        send_sample('0, 1'b1, 1'b0);
        send_sample('1, 1'b0, 1'b1);                  // period end ignored, no close
        send_sample('0, 1'b1, 1'b1);
        for (int i = 0; i < 8; i++) send_sample(i[0] ? 12'hFFF : 12'h000, i == 7, 1'b0);
        send_sample(12'd2048, 1'b1, 1'b1);
        send_sample(12'hA5A, 1'b1, 1'b0);             // window close right after a period close
    endtask

    task automatic test_register_corners();
        configure(23'h007FFF, 23'd0, 23'd0);          // zero floor and zero length
        repeat (3) send_sample(12'hFFF, 1'b0, 1'b0);
        send_sample(12'h123, 1'b0, 1'b1);
        configure(23'h7F8000, 23'h7FFFFF, 23'd3);     // minimum offset, huge floor
        repeat (6) send_sample(SB'($urandom_range(4095)), 1'b0, 1'b0);
        send_sample(12'h000, 1'b0, 1'b1);
        configure(23'h007FFF, 23'd4194304, 23'd2);
        send_sample(12'h000, 1'b0, 1'b0);
        send_sample(12'hFFF, 1'b0, 1'b1);
        wait_drained();
        write_reg(REG_SPARE, 23'h555555);
        configure(23'h000000, 23'd1, 23'd2047);       // length above depth
        for (int i = 0; i < 20; i++) send_sample(SB'($urandom_range(4095)), 1'b0, 1'b0);
        send_sample(12'h0F0, 1'b1, 1'b1);
    endtask

    task automatic test_random_phase(input int s_idle, r_idle, n_items);
        logic [CFW-1:0] mx;
        logic [SB-1:0] center;
        bit we, pe;
        mx = ($urandom_range(9) == 0) ? CFW'($urandom_range(2047)) : CFW'($urandom_range(40));
        configure(CFW'($urandom),
                  ($urandom_range(3) == 0) ? CFW'($urandom) : CFW'($urandom_range(4096)), mx);
        send_idle = s_idle;
        recv_idle = r_idle;
        center = SB'($urandom);
        for (int i = 0; i < n_items; i++)
        begin
            we = ($urandom_range(11) == 0);
            pe = ($urandom_range(2) == 0);
            if ($urandom_range(3) == 0) center = SB'($urandom);
            if ($urandom_range(1))
                send_sample(SB'($urandom), we, pe);
            else
                send_sample(center ^ SB'($urandom_range(7)), we, pe);
            if (i == n_items / 2) wait_drained();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_register_corners();
        test_random_phase(37, 73, 170);
        test_random_phase(73, 37, 170);
        test_random_phase(0, 0, 170);
        wait_drained();
        $display("covered %0d samples, %0d windows and %0d averaging periods", items_sent,
                 windows_seen, periods_seen);
        $display("register corners, zero and oversize lengths, three idling mixes, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && level_q.size() == 0)
            $display("tb_sound_level_meter_db_unit OK");
        else
            $display("tb_sound_level_meter_db_unit NOT OK");
        $finish;
    end

endmodule
